// ===== rtl/assert_macros.svh =====
// assertion macros used by nearest_texture_sampler_core
// no dependencies; the checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_AT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

// ===== rtl/ntex_pkg.sv =====
// constants and codes for the nearest texture sampler
// no dependencies; used by nearest_texture_sampler_core
`default_nettype none

package ntex_pkg;

    // texel store geometry
    localparam int STORE_BYTES  = 262144;
    localparam int BYTE_ADDR_W  = $clog2(STORE_BYTES);
    localparam int STORE_WORDS  = STORE_BYTES / 4;
    localparam int WORD_ADDR_W  = BYTE_ADDR_W - 2;

    // texture geometry
    localparam int MAX_DIM      = 256;
    localparam int DIM_W        = 9;
    localparam int POS_W        = 8;
    localparam int PIX_IDX_W    = 16;

    // coordinates, signed q8.16
    localparam int COORD_W      = 24;
    localparam int FRAC_W       = 16;
    localparam int ONE_Q16      = 65536;

    // configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_S  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_T  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 3'd5;

    // pixel formats
    localparam logic [1:0] FMT_LUM  = 2'd0;
    localparam logic [1:0] FMT_RGBA = 2'd1;

    // request kinds
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [7:0] FULL_SCALE = 8'd255;

endpackage

`default_nettype wire

// ===== rtl/nearest_texture_sampler_core.sv =====
// nearest texture sampler: wrap, scale, address and fetch over a 32-bit wide texel store
// depends on ntex_pkg and assert_macros.svh
// a sample beat passes capture, wrap/scale, address and store read before its result is shown
// throughput: one beat (write or sample) per cycle while no finished result waits;
//   the single texel store port serves either one byte write or one 32-bit read each cycle
// reset: synchronous active-low aresetn clears pipeline valids and resets config registers;
//   the texel store is not cleared and reads undefined until written
`default_nettype none

`include "assert_macros.svh"

module nearest_texture_sampler_core (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration
    input  wire logic                                  cfg_wr_en,
    input  wire logic [ntex_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  wire logic [ntex_pkg::CFG_DATA_W-1:0]       cfg_data,
    // request channel
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_req_type,
    input  wire logic [ntex_pkg::BYTE_ADDR_W-1:0]      s_byte_addr,
    input  wire logic [7:0]                            s_byte_data,
    input  wire logic signed [ntex_pkg::COORD_W-1:0]   s_u_coord,
    input  wire logic signed [ntex_pkg::COORD_W-1:0]   s_v_coord,
    // result channel
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [7:0]                                 m_red,
    output logic [7:0]                                 m_green,
    output logic [7:0]                                 m_blue,
    output logic [7:0]                                 m_alpha
);

    // wrap one coordinate into [0, one]
    function automatic logic [ntex_pkg::FRAC_W:0] wrap_axis(
        input logic signed [ntex_pkg::COORD_W-1:0] c,
        input logic                                rep
    );
        logic [ntex_pkg::COORD_W:0] neg;
        logic                       above_one;
        logic [ntex_pkg::FRAC_W:0]  res;
        neg       = (ntex_pkg::COORD_W+1)'(0) - {c[ntex_pkg::COORD_W-1], c};
        above_one = c[ntex_pkg::COORD_W-2:0] >
                    (ntex_pkg::COORD_W-1)'(ntex_pkg::ONE_Q16);
        if (!rep) begin
            if (c[ntex_pkg::COORD_W-1]) begin
                res = '0;
            end else if (above_one) begin
                res = (ntex_pkg::FRAC_W+1)'(ntex_pkg::ONE_Q16);
            end else begin
                res = c[ntex_pkg::FRAC_W:0];
            end
        end else begin
            if (c[ntex_pkg::COORD_W-1]) begin
                res = {1'b0, neg[ntex_pkg::FRAC_W-1:0]};
            end else if (above_one) begin
                res = {1'b0, c[ntex_pkg::FRAC_W-1:0]};
            end else begin
                res = c[ntex_pkg::FRAC_W:0];
            end
        end
        return res;
    endfunction

    // dimension of 0 acts as 1, above the maximum acts as the maximum
    function automatic logic [ntex_pkg::DIM_W-1:0] eff_dim(
        input logic [ntex_pkg::DIM_W-1:0] d
    );
        logic [ntex_pkg::DIM_W-1:0] res;
        if (d == '0) begin
            res = ntex_pkg::DIM_W'(1);
        end else if (d > ntex_pkg::DIM_W'(ntex_pkg::MAX_DIM)) begin
            res = ntex_pkg::DIM_W'(ntex_pkg::MAX_DIM);
        end else begin
            res = d;
        end
        return res;
    endfunction

    localparam int PROD_W = ntex_pkg::FRAC_W + 1 + ntex_pkg::DIM_W;
    localparam int SCL_W  = PROD_W - ntex_pkg::FRAC_W;
    localparam int ROW_W  = ntex_pkg::POS_W + ntex_pkg::DIM_W;

    // configuration registers
    logic                          present_reg;
    logic                          wrap_s_reg;
    logic                          wrap_t_reg;
    logic [ntex_pkg::DIM_W-1:0]    width_reg;
    logic [ntex_pkg::DIM_W-1:0]    height_reg;
    logic [1:0]                    format_reg;

    // pipeline registers
    logic                                  p1_valid_reg;
    logic                                  p1_sample_reg;
    logic [ntex_pkg::BYTE_ADDR_W-1:0]      p1_addr_reg;
    logic [7:0]                            p1_data_reg;
    logic signed [ntex_pkg::COORD_W-1:0]   p1_u_reg;
    logic signed [ntex_pkg::COORD_W-1:0]   p1_v_reg;

    logic                                  p2_valid_reg;
    logic                                  p2_sample_reg;
    logic [ntex_pkg::BYTE_ADDR_W-1:0]      p2_addr_reg;
    logic [7:0]                            p2_data_reg;
    logic [SCL_W-1:0]                      p2_x_reg;
    logic [SCL_W-1:0]                      p2_y_reg;

    logic                                  p3_valid_reg;
    logic                                  p3_sample_reg;
    logic [ntex_pkg::WORD_ADDR_W-1:0]      p3_word_reg;
    logic [1:0]                            p3_lane_reg;
    logic [7:0]                            p3_data_reg;

    logic                                  p4_valid_reg;
    logic [1:0]                            p4_lane_reg;
    logic [3:0][7:0]                       rdata_reg;

    // texel store, four byte lanes per word
    logic [3:0][7:0] tex_mem [ntex_pkg::STORE_WORDS];

    logic                                  adv;
    logic [ntex_pkg::DIM_W-1:0]            w_eff;
    logic [ntex_pkg::DIM_W-1:0]            h_eff;
    logic [ntex_pkg::DIM_W-1:0]            w_m1;
    logic [ntex_pkg::DIM_W-1:0]            h_m1;
    logic [ntex_pkg::FRAC_W:0]             u_wr;
    logic [ntex_pkg::FRAC_W:0]             v_wr;
    logic [ntex_pkg::FRAC_W:0]             v_flip;
    logic [PROD_W-1:0]                     x_prod;
    logic [PROD_W-1:0]                     y_prod;
    logic [ntex_pkg::POS_W-1:0]            x_cl;
    logic [ntex_pkg::POS_W-1:0]            y_cl;
    logic [ROW_W-1:0]                      idx_full;
    logic [ntex_pkg::PIX_IDX_W-1:0]        idx;
    logic [ntex_pkg::WORD_ADDR_W-1:0]      word_next;
    logic [1:0]                            lane_next;
    logic                                  white;
    logic [7:0]                            lum;

    // whole pipeline moves unless a finished result waits
    assign adv     = !p4_valid_reg || m_ready;
    assign s_ready = adv;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
            wrap_s_reg  <= 1'b1;
            wrap_t_reg  <= 1'b1;
            width_reg   <= ntex_pkg::DIM_W'(ntex_pkg::MAX_DIM);
            height_reg  <= ntex_pkg::DIM_W'(ntex_pkg::MAX_DIM);
            format_reg  <= ntex_pkg::FMT_RGBA;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx)
                ntex_pkg::CFG_PRESENT: present_reg <= cfg_data[0];
                ntex_pkg::CFG_WRAP_S:  wrap_s_reg  <= cfg_data[0];
                ntex_pkg::CFG_WRAP_T:  wrap_t_reg  <= cfg_data[0];
                ntex_pkg::CFG_WIDTH:   width_reg   <= cfg_data;
                ntex_pkg::CFG_HEIGHT:  height_reg  <= cfg_data;
                ntex_pkg::CFG_FORMAT:  format_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // stage 1: capture the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_sample_reg <= s_req_type == ntex_pkg::REQ_SAMPLE;
            p1_addr_reg   <= s_byte_addr;
            p1_data_reg   <= s_byte_data;
            p1_u_reg      <= s_u_coord;
            p1_v_reg      <= s_v_coord;
        end
    end

    // stage 1 logic: wrap, flip v and scale by the texture size
    always_comb begin
        w_eff  = eff_dim(width_reg);
        h_eff  = eff_dim(height_reg);
        w_m1   = w_eff - ntex_pkg::DIM_W'(1);
        h_m1   = h_eff - ntex_pkg::DIM_W'(1);
        u_wr   = wrap_axis(p1_u_reg, wrap_s_reg);
        v_wr   = wrap_axis(p1_v_reg, wrap_t_reg);
        v_flip = (ntex_pkg::FRAC_W+1)'(ntex_pkg::ONE_Q16) - v_wr;
        x_prod = PROD_W'(u_wr) * PROD_W'(w_eff);
        y_prod = PROD_W'(v_flip) * PROD_W'(h_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_sample_reg <= p1_sample_reg;
            p2_addr_reg   <= p1_addr_reg;
            p2_data_reg   <= p1_data_reg;
            p2_x_reg      <= x_prod[PROD_W-1:ntex_pkg::FRAC_W];
            p2_y_reg      <= y_prod[PROD_W-1:ntex_pkg::FRAC_W];
        end
    end

    // stage 2 logic: clamp to the last texel, form the texel index and store word (from the byte address for writes)
    always_comb begin
        x_cl = (p2_x_reg > SCL_W'(w_m1)) ? w_m1[ntex_pkg::POS_W-1:0]
                                         : p2_x_reg[ntex_pkg::POS_W-1:0];
        y_cl = (p2_y_reg > SCL_W'(h_m1)) ? h_m1[ntex_pkg::POS_W-1:0]
                                         : p2_y_reg[ntex_pkg::POS_W-1:0];
        idx_full = ROW_W'(y_cl) * ROW_W'(w_eff) + ROW_W'(x_cl);
        idx      = idx_full[ntex_pkg::PIX_IDX_W-1:0];
        if (!p2_sample_reg) begin
            word_next = p2_addr_reg[ntex_pkg::BYTE_ADDR_W-1:2];
            lane_next = p2_addr_reg[1:0];
        end else if (format_reg == ntex_pkg::FMT_LUM) begin
            word_next = ntex_pkg::WORD_ADDR_W'(idx[ntex_pkg::PIX_IDX_W-1:2]);
            lane_next = idx[1:0];
        end else begin
            word_next = ntex_pkg::WORD_ADDR_W'(idx);
            lane_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (adv) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_sample_reg <= p2_sample_reg;
            p3_word_reg   <= word_next;
            p3_lane_reg   <= lane_next;
            p3_data_reg   <= p2_data_reg;
        end
    end

    // stage 3: texel store access, writes and reads kept in beat order
    always_ff @(posedge aclk) begin
        if (adv && p3_valid_reg) begin
            if (p3_sample_reg) begin
                rdata_reg <= tex_mem[p3_word_reg];
            end else begin
                tex_mem[p3_word_reg][p3_lane_reg] <= p3_data_reg;
            end
        end
    end

    // stage 4: result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else if (adv) begin
            p4_valid_reg <= p3_valid_reg && p3_sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_lane_reg <= p3_lane_reg;
        end
    end

    // channel select, white when nothing usable is bound
    always_comb begin
        white = !present_reg || (format_reg != ntex_pkg::FMT_LUM &&
                                 format_reg != ntex_pkg::FMT_RGBA);
        lum   = rdata_reg[p4_lane_reg];
        if (white) begin
            m_red   = ntex_pkg::FULL_SCALE;
            m_green = ntex_pkg::FULL_SCALE;
            m_blue  = ntex_pkg::FULL_SCALE;
            m_alpha = ntex_pkg::FULL_SCALE;
        end else if (format_reg == ntex_pkg::FMT_LUM) begin
            m_red   = lum;
            m_green = lum;
            m_blue  = lum;
            m_alpha = ntex_pkg::FULL_SCALE;
        end else begin
            m_red   = rdata_reg[0];
            m_green = rdata_reg[1];
            m_blue  = rdata_reg[2];
            m_alpha = rdata_reg[3];
        end
    end

    assign m_valid = p4_valid_reg;

    // checks
    // a store write never turns into a result
    `ASSERT_AT(a_write_no_result, aclk, aresetn,
               (adv && p3_valid_reg && !p3_sample_reg) |=> !p4_valid_reg)
    // read data holds while the pipeline is stalled
    `ASSERT_AT(a_rdata_held, aclk, aresetn, !adv |=> $stable(rdata_reg))
    // luminance reads stay in the lower quarter of the store
    `ASSERT_NEVER(a_lum_word_range, aclk, aresetn,
                  p3_valid_reg && p3_sample_reg && format_reg == ntex_pkg::FMT_LUM &&
                  p3_word_reg[ntex_pkg::WORD_ADDR_W-1:ntex_pkg::WORD_ADDR_W-2] != 2'd0)

endmodule

`default_nettype wire
